// ===== src/smf_pkg.sv =====
// shared types and constants of the running median filter
package smf_pkg;

  localparam int CHANNELS    = 5;
  localparam int SAMPLE_BITS = 10;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  // one request: one sample per channel
  typedef struct packed {
    sample_t sample_ch4;
    sample_t sample_ch3;
    sample_t sample_ch2;
    sample_t sample_ch1;
    sample_t sample_ch0;
  } in_req_t;

  // one result: one median per channel
  typedef struct packed {
    sample_t median_ch4;
    sample_t median_ch3;
    sample_t median_ch2;
    sample_t median_ch1;
    sample_t median_ch0;
  } out_rsp_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic    gt;     // invalid, or holds a value above the incoming sample
    sample_t value;
  } cell_view_t;

  // per-cell control from the chain
  typedef struct packed {
    logic ins;       // a sample is inserted this cycle
    logic valid;     // cell holds a live sample
    logic sh_self;   // eviction at or below this cell
    logic sh_low;    // eviction at or below the lower neighbor
  } cell_ctl_t;

endpackage

// ===== src/smf_cell.sv =====
// one cell of the sorted window chain: value, age and insert/evict step
module smf_cell
  import smf_pkg::*;
#(
  parameter int WINDOW_LEN = 20,
  parameter int AGE_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  sample_t          new_sample,
  input  cell_view_t       low_view,
  input  logic [AGE_W-1:0] low_age,
  input  cell_view_t       up_view,
  input  logic [AGE_W-1:0] up_age,
  output cell_view_t       self_view,
  output logic [AGE_W-1:0] self_age,
  output logic             evict
);

  sample_t          value_r, value_nxt;
  logic [AGE_W-1:0] age_r, age_nxt;

  cell_view_t       s_self, s_low;
  logic [AGE_W-1:0] s_self_age, s_low_age;

  assign self_view.value = value_r;
  assign self_view.gt    = !ctl.valid || (value_r > new_sample);
  assign self_age        = age_r;
  // oldest sample of a full window
  assign evict           = ctl.valid && (age_r == AGE_W'(WINDOW_LEN - 1));

  always_comb begin
    // contents after the evicted cell is closed up
    s_self     = ctl.sh_self ? up_view : self_view;
    s_self_age = ctl.sh_self ? up_age : age_r;
    s_low      = ctl.sh_low ? self_view : low_view;
    s_low_age  = ctl.sh_low ? age_r : low_age;

    value_nxt = value_r;
    age_nxt   = age_r;
    if (ctl.ins) begin
      if (!s_self.gt) begin
        value_nxt = s_self.value;
        age_nxt   = s_self_age + AGE_W'(1);
      end else if (!s_low.gt) begin
        value_nxt = new_sample;
        age_nxt   = '0;
      end else begin
        value_nxt = s_low.value;
        age_nxt   = s_low_age + AGE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    age_r   <= age_nxt;
  end

endmodule

// ===== src/smf_chain.sv =====
// one channel: sorted row of cells and median select
module smf_chain
  import smf_pkg::*;
#(
  parameter int WINDOW_LEN = 20,
  parameter int AGE_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1,
  parameter int CNT_W      = $clog2(WINDOW_LEN + 1)
) (
  input  logic             clk,
  input  logic             ins,
  input  sample_t          new_sample,
  input  logic [CNT_W-1:0] count,
  output sample_t          median
);

  cell_view_t       view [WINDOW_LEN];
  logic [AGE_W-1:0] age  [WINDOW_LEN];
  logic [WINDOW_LEN-1:0] evict;
  logic [WINDOW_LEN-1:0] sh;

  // sh[i]: the evicted cell sits at index i or below
  always_comb begin
    logic acc;
    acc = 1'b0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      acc   = acc | evict[i];
      sh[i] = acc;
    end
  end

  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    cell_ctl_t        ctl;
    cell_view_t       low_v, up_v;
    logic [AGE_W-1:0] low_a, up_a;

    assign ctl.ins     = ins;
    assign ctl.valid   = (CNT_W'(i) < count);
    assign ctl.sh_self = sh[i];

    if (i == 0) begin : g_bottom
      assign ctl.sh_low = 1'b0;
      assign low_v      = '{gt: 1'b0, value: '0};
      assign low_a      = '0;
    end else begin : g_mid_low
      assign ctl.sh_low = sh[i-1];
      assign low_v      = view[i-1];
      assign low_a      = age[i-1];
    end

    if (i == WINDOW_LEN - 1) begin : g_top
      assign up_v = '{gt: 1'b1, value: '0};
      assign up_a = '0;
    end else begin : g_mid_up
      assign up_v = view[i+1];
      assign up_a = age[i+1];
    end

    smf_cell #(
      .WINDOW_LEN (WINDOW_LEN),
      .AGE_W      (AGE_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .new_sample (new_sample),
      .low_view   (low_v),
      .low_age    (low_a),
      .up_view    (up_v),
      .up_age     (up_a),
      .self_view  (view[i]),
      .self_age   (age[i]),
      .evict      (evict[i])
    );
  end

  // element count/2 of the sorted row
  assign median = view[AGE_W'(count >> 1)].value;

endmodule

// ===== src/sliding_window_median_filter.sv =====
// top level of the five-channel running median filter
//
// usage
//   in channel: one request carries one 10-bit sample per channel, taken
//   when in_valid and in_ready are both high
//   out channel: one result per request with the median of each channel's
//   window (element count/2 of the sorted window, the upper median for
//   even counts), in request order
//   each channel keeps a row of WINDOW_LEN cells sorted ascending; every
//   cell carries an age tag, so the oldest sample drops out and the new one
//   slides into place in the same cycle
//   a request updates the cell rows, then its result loads the output register;
//   one request per cycle while out_ready is high, set by the row insert step
//   during warm-up the median is taken over the samples seen so far
//   reset: the fill count and the handshake state clear; cell contents
//   are only read once written, so they need no clearing
//   stalls: a result waits in the output register while out_ready is low;
//   one more request is still taken and held in the cell rows, then in_ready
//   drops until the output register frees up
module sliding_window_median_filter
  import smf_pkg::*;
#(
  parameter int WINDOW_LEN = 20
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_rsp_t out_data
);

  localparam int CNT_W = $clog2(WINDOW_LEN + 1);

  logic [CNT_W-1:0] fill_count_r, fill_count_nxt;
  logic             pend_r, pend_nxt;        // cell rows hold an unreported update
  logic             out_valid_r, out_valid_nxt;
  out_rsp_t         out_data_r, out_data_nxt;

  logic    in_acc;
  logic    out_load;
  sample_t samples [CHANNELS];
  sample_t medians [CHANNELS];

  // request fields to channel lanes
  assign samples[0] = in_data.sample_ch0;
  assign samples[1] = in_data.sample_ch1;
  assign samples[2] = in_data.sample_ch2;
  assign samples[3] = in_data.sample_ch3;
  assign samples[4] = in_data.sample_ch4;

  // a pending update loads the output register when it is empty or draining
  assign out_load = pend_r && (!out_valid_r || out_ready);
  // new request may enter when none is pending or the pending one moves out
  assign in_ready = !pend_r || out_load;
  assign in_acc   = in_valid && in_ready;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
    smf_chain #(
      .WINDOW_LEN (WINDOW_LEN),
      .CNT_W      (CNT_W)
    ) u_chain (
      .clk        (clk),
      .ins        (in_acc),
      .new_sample (samples[c]),
      .count      (fill_count_r),
      .median     (medians[c])
    );
  end

  always_comb begin
    fill_count_nxt = fill_count_r;
    if (in_acc && (fill_count_r < CNT_W'(WINDOW_LEN))) begin
      fill_count_nxt = fill_count_r + CNT_W'(1);
    end

    pend_nxt = pend_r;
    if (in_acc) begin
      pend_nxt = 1'b1;
    end else if (out_load) begin
      pend_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.median_ch0 = medians[0];
      out_data_nxt.median_ch1 = medians[1];
      out_data_nxt.median_ch2 = medians[2];
      out_data_nxt.median_ch3 = medians[3];
      out_data_nxt.median_ch4 = medians[4];
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_count_r <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      fill_count_r <= fill_count_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
